// File: sv/cdq_pkg.sv
package cdq_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam int CMD_W = 3;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_NOP        = 3'd4
	} cmd_t;

	// operation broadcast to every cell of the row
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_REAR,
		OP_POP_FRONT,
		OP_POP_REAR,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic                      valid;
		logic signed [DATA_W-1:0] data;
	} slot_t;

endpackage

// File: sv/cdq_ifs.sv
interface cdq_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [cdq_pkg::CMD_W-1:0]               cmd;
	logic signed [cdq_pkg::DATA_W-1:0]       item_value;

	modport source (output valid, output cmd, output item_value, input ready);
	modport sink (input valid, input cmd, input item_value, output ready);
endinterface

interface cdq_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    ok;
	logic signed [cdq_pkg::DATA_W-1:0]       front_value;
	logic signed [cdq_pkg::DATA_W-1:0]       rear_value;
	logic                                    is_empty;
	logic                                    is_full;

	modport source (output valid, output ok, output front_value, output rear_value,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input ok, input front_value, input rear_value,
		input is_empty, input is_full, output ready);
endinterface

// File: sv/cdq_cell.sv
module cdq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  cdq_pkg::cell_ctl_t ctl,
	input  cdq_pkg::slot_t     left,
	input  cdq_pkg::slot_t     right,
	output cdq_pkg::slot_t     slot,
	output logic               is_rear
);
	import cdq_pkg::*;

	logic                      valid_q;
	logic signed [DATA_W-1:0] data_q;
	logic                      valid_d;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		case (ctl.op)
			OP_PUSH_FRONT: begin
				valid_d = left.valid;
				data_d  = left.data;
			end
			OP_POP_FRONT: begin
				valid_d = right.valid;
				data_d  = right.data;
			end
			OP_PUSH_REAR: begin
				// first free cell after the occupied run takes the value
				if (!valid_q && left.valid) begin
					valid_d = 1'b1;
					data_d  = ctl.value;
				end
			end
			OP_POP_REAR: begin
				if (valid_q && !right.valid) begin
					valid_d = 1'b0;
				end
			end
			OP_CLEAR: begin
				valid_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign slot.valid = valid_q;
	assign slot.data  = data_q;
	assign is_rear    = valid_q && !right.valid;

endmodule

// File: sv/circular_deque.sv
// A command updates the cell row, then its result is captured into the output register.
// Throughput: one command per cycle while the result side takes every result;
// a stalled result blocks at most one further command, held in the cell row.
// Reset: all cells empty, capacity 16 (the full row), no result pending.
// A capacity write empties the deque at once.
module circular_deque (
	input  logic                        clk,
	input  logic                        arst_n,
	cdq_req_if.sink                     req,
	cdq_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]   cfg_wdata
);
	import cdq_pkg::*;

	// The deque lives in a row of cells. Cell 0 is always the front, and the
	// occupied cells form one run from cell 0. Push front shifts the row toward
	// the back, pop front shifts it toward the front; rear operations touch only
	// the cell at the end of the run, which each cell finds from its neighbors.

	cell_ctl_t ctl;
	slot_t     cells [DEPTH];
	logic      rear_hit [DEPTH];

	cnt_t count_q, count_d;
	cnt_t cap_q;
	logic pending_q;
	logic ok_s1;
	logic ok_d;
	logic out_valid_q;

	logic accept;
	logic capture;
	logic full_now;
	logic empty_now;

	logic                      out_ok_q;
	logic signed [DATA_W-1:0] out_front_q;
	logic signed [DATA_W-1:0] out_rear_q;
	logic                      out_empty_q;
	logic                      out_full_q;

	logic signed [DATA_W-1:0] rear_data;

	// Row of cells; the front neighbor of cell 0 is the incoming value, the
	// back neighbor of the last cell is an empty slot.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		slot_t left_in;
		slot_t right_in;

		if (i == 0) begin : g_first
			assign left_in.valid = 1'b1;
			assign left_in.data  = ctl.value;
		end else begin : g_mid_l
			assign left_in = cells[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_mid_r
			assign right_in = cells[i+1];
		end

		cdq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.left    (left_in),
			.right   (right_in),
			.slot    (cells[i]),
			.is_rear (rear_hit[i])
		);
	end

	assign full_now  = (count_q == cap_q);
	assign empty_now = (count_q == '0);

	// capture the result when the output register is free or being drained
	assign capture = pending_q && (!out_valid_q || rsp.ready);
	assign accept  = req.valid && req.ready;

	// a new command may enter in the cycle its predecessor's result is captured
	assign req.ready = !pending_q || capture;

	// Decode the command against the current fill; refused commands hold the row.
	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.value = req.item_value;
		count_d   = count_q;
		ok_d      = 1'b1;
		if (cfg_we) begin
			ctl.op  = OP_CLEAR;
			count_d = '0;
		end else if (accept) begin
			case (cmd_t'(req.cmd))
				CMD_PUSH_FRONT: begin
					if (full_now) begin
						ok_d = 1'b0;
					end else begin
						ctl.op  = OP_PUSH_FRONT;
						count_d = count_q + cnt_t'(1);
					end
				end
				CMD_PUSH_REAR: begin
					if (full_now) begin
						ok_d = 1'b0;
					end else begin
						ctl.op  = OP_PUSH_REAR;
						count_d = count_q + cnt_t'(1);
					end
				end
				CMD_POP_FRONT: begin
					if (empty_now) begin
						ok_d = 1'b0;
					end else begin
						ctl.op  = OP_POP_FRONT;
						count_d = count_q - cnt_t'(1);
					end
				end
				CMD_POP_REAR: begin
					if (empty_now) begin
						ok_d = 1'b0;
					end else begin
						ctl.op  = OP_POP_REAR;
						count_d = count_q - cnt_t'(1);
					end
				end
				default: begin
					// no operation, and the unused codes act the same
				end
			endcase
		end
	end

	// Exactly one cell flags itself as rear while the deque holds entries.
	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_data = rear_data | ({DATA_W{rear_hit[i]}} & cells[i].data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= cnt_t'(DEPTH);
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cfg_we) begin
				// clamp capacity into 1..DEPTH
				if (cfg_wdata == '0) begin
					cap_q <= cnt_t'(1);
				end else if (int'(cfg_wdata) > DEPTH) begin
					cap_q <= cnt_t'(DEPTH);
				end else begin
					cap_q <= cnt_t'(cfg_wdata);
				end
			end
			if (accept) begin
				pending_q <= 1'b1;
			end else if (capture) begin
				pending_q <= 1'b0;
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: ok travels alongside the row update, the rest is read
	// from the row once it holds the state after the command.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1 <= ok_d;
		end
		if (capture) begin
			out_ok_q    <= ok_s1;
			out_empty_q <= empty_now;
			out_full_q  <= full_now;
			out_front_q <= empty_now ? -32'sd1 : cells[0].data;
			out_rear_q  <= empty_now ? -32'sd1 : rear_data;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = out_ok_q;
	assign rsp.front_value = out_front_q;
	assign rsp.rear_value  = out_rear_q;
	assign rsp.is_empty    = out_empty_q;
	assign rsp.is_full     = out_full_q;

endmodule
